// ----- design/utr_pkg.sv -----
// utr_pkg: shared types and constants for the utf-8 / utf-16 transcoder
// used by the channel interfaces, the decoder, the encoder and the top level
// no dependencies
package utr_pkg;

	// conversion codes
	localparam logic [2:0] OP_U8_CP   = 3'd0;
	localparam logic [2:0] OP_CP_U8   = 3'd1;
	localparam logic [2:0] OP_U16_CP  = 3'd2;
	localparam logic [2:0] OP_CP_U16  = 3'd3;
	localparam logic [2:0] OP_U8_U16  = 3'd4;
	localparam logic [2:0] OP_U16_U8  = 3'd5;

	localparam int CP_W = 27;

	localparam logic [CP_W-1:0] CP_MAX_1B  = 27'h00007F;
	localparam logic [CP_W-1:0] CP_MAX_2B  = 27'h0007FF;
	localparam logic [CP_W-1:0] CP_MAX_BMP = 27'h00FFFF;
	localparam logic [CP_W-1:0] CP_MAX     = 27'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUPP    = 27'h010000;
	localparam logic [CP_W-1:0] SURR_LO    = 27'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 27'h00DFFF;

	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  in_len;
		logic [15:0] in_unit0;
		logic [15:0] in_unit1;
		logic [7:0]  in_unit2;
		logic [7:0]  in_unit3;
		logic [20:0] in_code_point;
	} in_item_t;

	typedef struct packed {
		logic [26:0] out_code_point;
		logic [2:0]  out_len;
		logic [15:0] out_unit0;
		logic [15:0] out_unit1;
		logic [7:0]  out_unit2;
		logic [7:0]  out_unit3;
		logic        error;
	} out_item_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            ok;
	} dec_res_t;

	typedef struct packed {
		logic [2:0]  len;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic [7:0]  unit2;
		logic [7:0]  unit3;
		logic        ok;
	} enc_res_t;

endpackage

// ----- design/utr_if.sv -----
// utr_if: valid/ready channel interfaces for request and result transactions
// depends on utr_pkg
interface utr_req_if;
	import utr_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface utr_rsp_if;
	import utr_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/utr_decode.sv -----
// utr_decode: utf-8 or utf-16 code units to code point, combinational
// depends on utr_pkg
module utr_decode (
	input  logic              utf16,
	input  logic [2:0]        len,
	input  logic [15:0]       unit0,
	input  logic [15:0]       unit1,
	input  logic [7:0]        unit2,
	input  logic [7:0]        unit3,
	output utr_pkg::dec_res_t res
);
	import utr_pkg::*;

	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [15:0] w0_off;
	logic [15:0] w1_off;

	assign b0 = unit0[7:0];
	assign b1 = unit1[7:0];
	// 16-bit wrapping offsets of a surrogate pair
	assign w0_off = unit0 - HI_SURR_BASE;
	assign w1_off = unit1 - LO_SURR_BASE;

	always_comb begin
		res = '0;
		if (utf16) begin
			case (len)
				3'd1: begin
					res.cp = {11'd0, unit0};
					res.ok = 1'b1;
				end
				3'd2: begin
					res.cp = {1'b0, w0_off, 10'd0} + {11'd0, w1_off} + CP_SUPP;
					res.ok = 1'b1;
				end
				default: res = '0;
			endcase
		end else begin
			// lead and continuation bytes are masked, not checked
			case (len)
				3'd1: begin
					res.cp = {19'd0, b0};
					res.ok = 1'b1;
				end
				3'd2: begin
					res.cp = {16'd0, b0[4:0], b1[5:0]};
					res.ok = 1'b1;
				end
				3'd3: begin
					res.cp = {11'd0, b0[3:0], b1[5:0], unit2[5:0]};
					res.ok = 1'b1;
				end
				3'd4: begin
					res.cp = {6'd0, b0[2:0], b1[5:0], unit2[5:0], unit3[5:0]};
					res.ok = 1'b1;
				end
				default: res = '0;
			endcase
		end
	end

endmodule

// ----- design/utr_encode.sv -----
// utr_encode: code point to utf-8 bytes or utf-16 words, combinational
// depends on utr_pkg
module utr_encode (
	input  logic              utf16,
	input  logic [26:0]       cp,
	output utr_pkg::enc_res_t res
);
	import utr_pkg::*;

	logic [19:0] v;

	// offset into the supplementary planes
	assign v = cp[19:0] - CP_SUPP[19:0];

	always_comb begin
		res = '0;
		if (utf16) begin
			if (cp <= CP_MAX_BMP && (cp < SURR_LO || cp > SURR_HI)) begin
				res.len   = 3'd1;
				res.unit0 = cp[15:0];
				res.ok    = 1'b1;
			end else if (cp >= CP_SUPP && cp <= CP_MAX) begin
				res.len   = 3'd2;
				res.unit0 = HI_SURR_BASE + {6'd0, v[19:10]};
				res.unit1 = LO_SURR_BASE + {6'd0, v[9:0]};
				res.ok    = 1'b1;
			end
		end else begin
			if (cp <= CP_MAX_1B) begin
				res.len   = 3'd1;
				res.unit0 = {9'd0, cp[6:0]};
				res.ok    = 1'b1;
			end else if (cp <= CP_MAX_2B) begin
				res.len   = 3'd2;
				res.unit0 = {8'd0, LEAD_2B + {3'd0, cp[10:6]}};
				res.unit1 = {8'd0, CONT_B + {2'd0, cp[5:0]}};
				res.ok    = 1'b1;
			end else if (cp <= CP_MAX_BMP) begin
				res.len   = 3'd3;
				res.unit0 = {8'd0, LEAD_3B + {4'd0, cp[15:12]}};
				res.unit1 = {8'd0, CONT_B + {2'd0, cp[11:6]}};
				res.unit2 = CONT_B + {2'd0, cp[5:0]};
				res.ok    = 1'b1;
			end else if (cp <= CP_MAX) begin
				res.len   = 3'd4;
				res.unit0 = {8'd0, LEAD_4B + {5'd0, cp[20:18]}};
				res.unit1 = {8'd0, CONT_B + {2'd0, cp[17:12]}};
				res.unit2 = CONT_B + {2'd0, cp[11:6]};
				res.unit3 = CONT_B + {2'd0, cp[5:0]};
				res.ok    = 1'b1;
			end
		end
	end

endmodule

// ----- design/utf8_utf16_transcoder.sv -----
// utf8_utf16_transcoder: one-character utf-8 / utf-16 / code point converter
// depends on utr_pkg, utr_if, utr_decode and utr_encode
//
// usage
//   req carries one character per transaction: op picks the conversion,
//   in_len the number of code units, in_unit0..3 the units and
//   in_code_point the value to encode for the two encode-only ops
//   rsp carries exactly one result transaction per request
//   rsp.valid rises once the request has passed the input register and the
//   result register; while rsp.ready stays high the throughput is one
//   character per cycle: an input register feeds the decoder and encoder,
//   whose result is caught in a result register
//   reset (arst_n low) empties both registers; payload is not cleared
//   when rsp.ready is low the result register holds; the input register
//   still takes one more transaction, after which req.ready drops until
//   the result is taken
//   bad lengths, unknown ops, out-of-range code points to encode and
//   surrogates to encode as utf-16 give error set with every other field zero
module utf8_utf16_transcoder (
	input logic       clk,
	input logic       arst_n,
	utr_req_if.sink   req,
	utr_rsp_if.source rsp
);
	import utr_pkg::*;

	// stage registers
	logic      v_s1;
	in_item_t  item_s1;
	logic      v_s2;
	out_item_t res_s2;

	logic      adv_s2;
	dec_res_t  dec;
	enc_res_t  enc;
	logic      src_utf16;
	logic      dst_utf16;
	logic      enc_direct;
	logic [26:0] enc_cp;
	logic      ok;
	out_item_t res_c;

	// result register frees when empty or when its transaction is taken
	assign adv_s2    = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (adv_s2 && v_s1) begin
			res_s2 <= res_c;
		end
	end

	// route the conversion: which side decodes, which side encodes
	assign src_utf16  = (item_s1.op == OP_U16_CP) || (item_s1.op == OP_U16_U8);
	assign dst_utf16  = (item_s1.op == OP_CP_U16) || (item_s1.op == OP_U8_U16);
	assign enc_direct = (item_s1.op == OP_CP_U8) || (item_s1.op == OP_CP_U16);
	assign enc_cp     = enc_direct ? {6'd0, item_s1.in_code_point} : dec.cp;

	utr_decode u_decode (
		.utf16 (src_utf16),
		.len   (item_s1.in_len),
		.unit0 (item_s1.in_unit0),
		.unit1 (item_s1.in_unit1),
		.unit2 (item_s1.in_unit2),
		.unit3 (item_s1.in_unit3),
		.res   (dec)
	);

	utr_encode u_encode (
		.utf16 (dst_utf16),
		.cp    (enc_cp),
		.res   (enc)
	);

	always_comb begin
		case (item_s1.op)
			OP_U8_CP, OP_U16_CP: ok = dec.ok;
			OP_CP_U8, OP_CP_U16: ok = enc.ok;
			OP_U8_U16, OP_U16_U8: ok = dec.ok && enc.ok;
			default: ok = 1'b0;
		endcase
	end

	always_comb begin
		res_c = '0;
		if (!ok) begin
			// any failure clears the whole result and flags it
			res_c.error = 1'b1;
		end else if (item_s1.op == OP_U8_CP || item_s1.op == OP_U16_CP) begin
			res_c.out_code_point = dec.cp;
		end else begin
			res_c.out_len   = enc.len;
			res_c.out_unit0 = enc.unit0;
			res_c.out_unit1 = enc.unit1;
			res_c.out_unit2 = enc.unit2;
			res_c.out_unit3 = enc.unit3;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.data  = res_s2;

	// an accepted request always lands in the input register
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted request lost before input register");

	// a held input item is not overwritten while the result side stalls
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s2 |=> v_s1 && $stable(item_s1))
		else $error("input register changed during stall");

	// an empty input register never blocks the request channel
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> req.ready)
		else $error("request channel blocked with empty input register");

	// an error result carries a zero length, no code point and zero unit0 and unit1
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.error |->
			rsp.data.out_len == 3'd0 && rsp.data.out_code_point == 27'd0 &&
			rsp.data.out_unit0 == 16'd0 && rsp.data.out_unit1 == 16'd0)
		else $error("error result with nonzero payload");

	// an encoded result never also carries a decoded code point
	a_enc_no_cp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.out_len != 3'd0 |->
			rsp.data.out_code_point == 27'd0 && !rsp.data.error)
		else $error("encoded result carries a code point");

endmodule

// ----- sim/tb_utf8_utf16_transcoder.sv -----
// tb_utf8_utf16_transcoder: self-checking bench for the one-character utf-8 / utf-16 transcoder
// depends on utr_pkg, utr_if and utf8_utf16_transcoder
// predicts each result in place, then checks every result transaction under random stalls
module tb_utf8_utf16_transcoder;
	timeunit 1ns;
	timeprecision 1ps;

	import utr_pkg::*;

	// the two unassigned conversion codes
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	logic clk;
	logic arst_n;

	utr_req_if req_ch ();
	utr_rsp_if rsp_ch ();

	utf8_utf16_transcoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// conversions accepted by the block whose results have not come back yet
	out_item_t pending_conversions[$];

	// stall odds in percent, changed per random phase
	int unsigned src_idle_pct  = 32;
	int unsigned sink_idle_pct = 47;

	int mismatches      = 0;
	int results_checked = 0;
	int chars_by_op[8];

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------------
	// character predictor
	// ---------------------------------------------------------------------

	// lead and continuation bytes are masked, never validated
	function automatic bit utf8_to_cp(input in_item_t it, output logic [26:0] cp);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		b0 = it.in_unit0[7:0];
		b1 = it.in_unit1[7:0];
		b2 = it.in_unit2;
		b3 = it.in_unit3;
		cp = '0;
		case (it.in_len)
			3'd1: cp = {19'd0, b0};
			3'd2: cp = {16'd0, b0[4:0], b1[5:0]};
			3'd3: cp = {11'd0, b0[3:0], b1[5:0], b2[5:0]};
			3'd4: cp = {6'd0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// a pair is offset in 16-bit wrapping arithmetic, so junk pairs give big values
	function automatic bit utf16_to_cp(input in_item_t it, output logic [26:0] cp);
		logic [15:0] hi;
		logic [15:0] lo;
		logic [31:0] sum;
		cp = '0;
		case (it.in_len)
			3'd1: cp = {11'd0, it.in_unit0};
			3'd2: begin
				hi  = it.in_unit0 - HI_SURR_BASE;
				lo  = it.in_unit1 - LO_SURR_BASE;
				sum = {6'd0, hi, 10'd0} + {16'd0, lo} + 32'h0001_0000;
				cp  = sum[26:0];
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic bit cp_to_utf8(input logic [26:0] cp, output out_item_t enc);
		enc = '0;
		if (cp <= CP_MAX_1B) begin
			enc.out_len   = 3'd1;
			enc.out_unit0 = cp[15:0];
		end else if (cp <= CP_MAX_2B) begin
			enc.out_len   = 3'd2;
			enc.out_unit0 = {8'h00, LEAD_2B | {3'b000, cp[10:6]}};
			enc.out_unit1 = {8'h00, CONT_B | {2'b00, cp[5:0]}};
		end else if (cp <= CP_MAX_BMP) begin
			enc.out_len   = 3'd3;
			enc.out_unit0 = {8'h00, LEAD_3B | {4'b0000, cp[15:12]}};
			enc.out_unit1 = {8'h00, CONT_B | {2'b00, cp[11:6]}};
			enc.out_unit2 = CONT_B | {2'b00, cp[5:0]};
		end else if (cp <= CP_MAX) begin
			enc.out_len   = 3'd4;
			enc.out_unit0 = {8'h00, LEAD_4B | {5'b00000, cp[20:18]}};
			enc.out_unit1 = {8'h00, CONT_B | {2'b00, cp[17:12]}};
			enc.out_unit2 = CONT_B | {2'b00, cp[11:6]};
			enc.out_unit3 = CONT_B | {2'b00, cp[5:0]};
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// surrogate values and anything past the last plane cannot be encoded
	function automatic bit cp_to_utf16(input logic [26:0] cp, output out_item_t enc);
		logic [26:0] v;
		enc = '0;
		if (cp < SURR_LO || (cp > SURR_HI && cp <= CP_MAX_BMP)) begin
			enc.out_len   = 3'd1;
			enc.out_unit0 = cp[15:0];
		end else if (cp >= CP_SUPP && cp <= CP_MAX) begin
			v             = cp - CP_SUPP;
			enc.out_len   = 3'd2;
			enc.out_unit0 = HI_SURR_BASE + {6'd0, v[19:10]};
			enc.out_unit1 = LO_SURR_BASE + {6'd0, v[9:0]};
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic out_item_t transcode_char(input in_item_t it);
		out_item_t   res;
		logic [26:0] cp;
		bit          ok;
		res = '0;
		cp  = '0;
		ok  = 1'b0;
		case (it.op)
			OP_U8_CP: begin
				ok = utf8_to_cp(it, cp);
				res.out_code_point = cp;
			end
			OP_CP_U8:  ok = cp_to_utf8({6'd0, it.in_code_point}, res);
			OP_U16_CP: begin
				ok = utf16_to_cp(it, cp);
				res.out_code_point = cp;
			end
			OP_CP_U16: ok = cp_to_utf16({6'd0, it.in_code_point}, res);
			OP_U8_U16: begin
				if (utf8_to_cp(it, cp))
					ok = cp_to_utf16(cp, res);
			end
			OP_U16_U8: begin
				if (utf16_to_cp(it, cp))
					ok = cp_to_utf8(cp, res);
			end
			default: ok = 1'b0;
		endcase
		// any failure clears every field and raises the flag
		if (!ok) begin
			res       = '0;
			res.error = 1'b1;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	function automatic in_item_t char_item(input logic [2:0] op, input logic [2:0] len,
			input logic [15:0] u0, input logic [15:0] u1, input logic [7:0] u2,
			input logic [7:0] u3, input logic [20:0] cp);
		in_item_t it;
		it.op            = op;
		it.in_len        = len;
		it.in_unit0      = u0;
		it.in_unit1      = u1;
		it.in_unit2      = u2;
		it.in_unit3      = u3;
		it.in_code_point = cp;
		return it;
	endfunction

	// code points spread over every encoding length, the gaps and the boundaries
	function automatic logic [20:0] random_code_point();
		case ($urandom_range(7, 0))
			0: return 21'($urandom_range(32'h7F, 0));
			1: return 21'($urandom_range(32'h7FF, 32'h80));
			2: return 21'($urandom_range(32'hFFFF, 32'h800));
			3: return 21'($urandom_range(32'hDFFF, 32'hD800));
			4: return 21'($urandom_range(32'h10FFFF, 32'h10000));
			5: return 21'($urandom_range(32'h1FFFFF, 32'h110000));
			6: begin
				case ($urandom_range(9, 0))
					0: return 21'h00007F;
					1: return 21'h000080;
					2: return 21'h0007FF;
					3: return 21'h000800;
					4: return 21'h00D7FF;
					5: return 21'h00E000;
					6: return 21'h00FFFF;
					7: return 21'h010000;
					8: return 21'h10FFFF;
					default: return 21'h110000;
				endcase
			end
			default: return 21'($urandom);
		endcase
	endfunction

	// mostly well-formed units with random payload, one in ten pure noise
	function automatic in_item_t random_char();
		in_item_t it;
		bit       well_formed;
		it.op            = ($urandom_range(24, 0) == 0)
		                 ? (($urandom_range(1, 0) == 0) ? OP_BAD6 : OP_BAD7)
		                 : 3'($urandom_range(5, 0));
		it.in_len        = 3'($urandom_range(7, 0));
		it.in_unit0      = 16'($urandom);
		it.in_unit1      = 16'($urandom);
		it.in_unit2      = 8'($urandom);
		it.in_unit3      = 8'($urandom);
		it.in_code_point = random_code_point();
		well_formed      = ($urandom_range(9, 0) != 0);
		if (well_formed && (it.op == OP_U8_CP || it.op == OP_U8_U16)) begin
			it.in_len = 3'($urandom_range(4, 1));
			case (it.in_len)
				3'd1: it.in_unit0[7] = 1'b0;
				3'd2: it.in_unit0[7:5] = 3'b110;
				3'd3: it.in_unit0[7:4] = 4'b1110;
				default: it.in_unit0[7:3] = 5'b11110;
			endcase
			it.in_unit1[7:6] = 2'b10;
			it.in_unit2[7:6] = 2'b10;
			it.in_unit3[7:6] = 2'b10;
		end else if (well_formed && (it.op == OP_U16_CP || it.op == OP_U16_U8)) begin
			it.in_len = 3'($urandom_range(2, 1));
			// a proper high / low surrogate pair
			if (it.in_len == 3'd2) begin
				it.in_unit0[15:10] = 6'b110110;
				it.in_unit1[15:10] = 6'b110111;
			end
		end
		return it;
	endfunction

	// one request transaction; entered and left on a falling edge, valid is
	// left high so back-to-back characters keep valid asserted without a gap
	task automatic push_char(input in_item_t item);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_conversions = {pending_conversions, transcode_char(item)};
		chars_by_op[item.op]++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------------

	// receiver stalls at random, decided each falling edge
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, field, want, got);
		end
	endtask

	// every result transaction is matched against the oldest prediction
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			if (pending_conversions.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with nothing outstanding, expected none, actual 0x%0h",
					$time, rsp_ch.data);
			end else begin
				want = pending_conversions.pop_front();
				check_field("out_code_point", 32'(want.out_code_point),
					32'(rsp_ch.data.out_code_point));
				check_field("out_len", 32'(want.out_len), 32'(rsp_ch.data.out_len));
				check_field("out_unit0", 32'(want.out_unit0), 32'(rsp_ch.data.out_unit0));
				check_field("out_unit1", 32'(want.out_unit1), 32'(rsp_ch.data.out_unit1));
				check_field("out_unit2", 32'(want.out_unit2), 32'(rsp_ch.data.out_unit2));
				check_field("out_unit3", 32'(want.out_unit3), 32'(rsp_ch.data.out_unit3));
				check_field("error", 32'(want.error), 32'(rsp_ch.data.error));
				results_checked++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// every utf-8 length, raw byte pass-through, unchecked junk and a bad length
	task automatic test_utf8_decode();
		push_char(char_item(OP_U8_CP, 3'd1, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 21'h1FFFFF));
		push_char(char_item(OP_U8_CP, 3'd2, 16'h00C2, 16'h0080, 8'h00, 8'h00, '0));
		push_char(char_item(OP_U8_CP, 3'd3, 16'h00EF, 16'h00BF, 8'hBF, 8'h00, '0));
		push_char(char_item(OP_U8_CP, 3'd4, 16'h00F4, 16'h008F, 8'hBF, 8'hBF, '0));
		push_char(char_item(OP_U8_CP, 3'd4, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, '0));
		push_char(char_item(OP_U8_CP, 3'd0, 16'h0041, 16'h0000, 8'h00, 8'h00, '0));
	endtask

	// length boundaries of utf-8 encoding and the first value out of range
	task automatic test_utf8_encode();
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h000000));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h00007F));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h000080));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h0007FF));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h00FFFF));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h10FFFF));
		push_char(char_item(OP_CP_U8, 3'd0, '0, '0, '0, '0, 21'h110000));
	endtask

	// pair decoding incl. the wrapping junk pair and a bad length, surrogate rejection on encode
	task automatic test_utf16();
		push_char(char_item(OP_U16_CP, 3'd2, 16'hD800, 16'hDC00, '0, '0, '0));
		push_char(char_item(OP_U16_CP, 3'd2, 16'h0000, 16'h0000, '0, '0, '0));
		push_char(char_item(OP_U16_CP, 3'd3, 16'hD800, 16'hDC00, '0, '0, '0));
		push_char(char_item(OP_CP_U16, 3'd0, '0, '0, '0, '0, 21'h00D800));
		push_char(char_item(OP_CP_U16, 3'd0, '0, '0, '0, '0, 21'h00DFFF));
		push_char(char_item(OP_CP_U16, 3'd0, '0, '0, '0, '0, 21'h00E000));
		push_char(char_item(OP_CP_U16, 3'd0, '0, '0, '0, '0, 21'h10FFFF));
	endtask

	// chained conversions: decoded surrogates and oversized values, a bad op
	task automatic test_chained();
		push_char(char_item(OP_U8_U16, 3'd4, 16'h00F0, 16'h0090, 8'h80, 8'h80, '0));
		push_char(char_item(OP_U8_U16, 3'd3, 16'h00ED, 16'h00A0, 8'h80, 8'h00, '0));
		push_char(char_item(OP_U8_U16, 3'd4, 16'h00F7, 16'h00BF, 8'hBF, 8'hBF, '0));
		push_char(char_item(OP_U16_U8, 3'd2, 16'hDBFF, 16'hDFFF, '0, '0, '0));
		push_char(char_item(OP_U16_U8, 3'd2, 16'hFFFF, 16'hFFFF, '0, '0, '0));
		push_char(char_item(OP_U16_U8, 3'd1, 16'hD800, 16'h0000, '0, '0, '0));
		push_char(char_item(OP_BAD6, 3'd1, 16'h0041, '0, '0, '0, 21'h000041));
	endtask

	task automatic test_random(input int count, input int unsigned src_pct,
			input int unsigned sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (count)
			push_char(random_char());
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_utf8_decode();
		test_utf8_encode();
		test_utf16();
		test_chained();
		// sender stalls less than receiver, then the reverse, then full rate
		test_random(190, 32, 47);
		test_random(190, 47, 32);
		test_random(190, 0, 0);
		req_ch.valid <= 1'b0;

		// drain: wait until every prediction has been matched by a result
		while (pending_conversions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("checked %0d results: u8->cp %0d, cp->u8 %0d, u16->cp %0d, cp->u16 %0d",
			results_checked, chars_by_op[OP_U8_CP], chars_by_op[OP_CP_U8],
			chars_by_op[OP_U16_CP], chars_by_op[OP_CP_U16]);
		$display("u8->u16 %0d, u16->u8 %0d, bad op %0d; field mismatches %0d",
			chars_by_op[OP_U8_U16], chars_by_op[OP_U16_U8],
			chars_by_op[OP_BAD6] + chars_by_op[OP_BAD7], mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
design/utr_pkg.sv
design/utr_if.sv
design/utr_decode.sv
design/utr_encode.sv
design/utf8_utf16_transcoder.sv
sim/tb_utf8_utf16_transcoder.sv
